FILE: src/adt_pkg.sv
package adt_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WIN,
		S_AVG,
		S_CTRL,
		S_GROW,
		S_GSTEP,
		S_GAPPLY,
		S_TRY,
		S_TRY2,
		S_TRYP,
		S_TRYM,
		S_TRYA,
		S_SHRINK,
		S_DIV,
		S_OUT
	} state_t;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_NC  = 2'd0;
	localparam mode_t MODE_INC = 2'd1;
	localparam mode_t MODE_DEC = 2'd2;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_START_DELAY  = 3'd0;
	localparam cfg_idx_t REG_INJECT_TICKS = 3'd1;
	localparam cfg_idx_t REG_REDUCE_TICKS = 3'd2;
	localparam cfg_idx_t REG_SKIP_TICKS   = 3'd3;
	localparam cfg_idx_t REG_SETTLE_TICKS = 3'd4;
	localparam cfg_idx_t REG_DISABLE      = 3'd5;

	localparam logic [10:0] SAT_IN = 11'd2000;
	localparam logic [10:0] SCALE  = 11'd1000;
	localparam logic [10:0] G_HI   = 11'd1800;
	localparam logic [10:0] G_MID  = 11'd1100;
	localparam logic [31:0] C_HI   = 32'd900;
	localparam logic [31:0] C_QTR  = 32'd250;
	localparam logic [31:0] C_LO   = 32'd100;

	// reduction fraction, Q0.16
	localparam logic [15:0] P_MAX  = 16'd26214;
	localparam logic [14:0] P_SPAN = 15'd25559;
	localparam logic [31:0] P_DEN  = 32'd800;

	localparam logic [31:0] DIV_TOP  = 32'd15;
	localparam logic [31:0] DIV_HI   = 32'd10;
	localparam logic [31:0] DIV_MID  = 32'd20;
	localparam logic [31:0] DIV_LOW  = 32'd100;

	localparam logic [15:0] SKIP_TOP = 16'd40;
	localparam logic [15:0] SKIP_MID = 16'd32;
	localparam logic [15:0] SKIP_LOW = 16'd24;

	localparam logic [2:0] TRIES_FULL  = 3'd5;
	localparam logic [2:0] TRIES_SHORT = 3'd2;

endpackage

FILE: src/adt_in_if.sv
interface adt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] tree_sensor;
	logic [15:0] ingest_sensor;

	modport source(output valid, output tree_sensor, output ingest_sensor, input ready);
	modport sink(input valid, input tree_sensor, input ingest_sensor, output ready);
endinterface

FILE: src/adt_out_if.sv
interface adt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] delay;
	logic [1:0]  mode;
	logic [10:0] average;

	modport source(output valid, output delay, output mode, output average, input ready);
	modport sink(input valid, input delay, input mode, input average, output ready);
endinterface

FILE: src/adt_cfg_if.sv
interface adt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: src/adaptive_delay_throttle.sv
// channel  dir  payload                            transaction when
// sample   in   tree_sensor, ingest_sensor         valid && ready
// result   out  delay, mode, average               valid && ready
// cfg      in   index, data                        valid && ready (ready always high)
//
// A tick whose sample is skipped while the controller idles runs no division; at most
// three run in one tick: averaging, the load quotient and the fraction quotient.
// Each quotient is one pass of a shared 1-bit-per-cycle restoring divider.
// A sample is taken only in idle; S_OUT waits only on a full, stalled result register.
// arst_n clears all control state; window samples stay undefined until written.
module adaptive_delay_throttle
	import adt_pkg::*;
#(
	parameter int unsigned AVG_DEPTH    = 16,
	parameter int unsigned MAX_HIGH_RUN = 8,
	parameter logic [31:0] DELAY_MAX    = 32'd1000000,
	parameter logic [15:0] DELAY_MIN    = 16'd1
) (
	input  logic          clk,
	input  logic          arst_n,
	adt_in_if.sink        sample,
	adt_out_if.source     result,
	adt_cfg_if.sink       cfg
);

	localparam int POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W = $clog2(AVG_DEPTH * 2000 + 1);

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	state_t state_q, state_d;

	logic [31:0] start_delay_q;
	logic [15:0] inject_ticks_q, reduce_ticks_q, skip_ticks_q, settle_ticks_q;
	logic        disable_q;

	logic [31:0] delay_now_q, delay_before_q, delay_trial_q, last_inc_q;
	mode_t       mode_q;
	logic [15:0] monitor_q, skip_q, high_run_q;
	logic [2:0]  tries_done_q, tries_allowed_q;
	logic [19:0] inject_q;
	logic [31:0] reduce_sum_q;
	logic [10:0] tree_level_q;
	logic        started_q;

	logic [SUM_W-1:0]  win_sum_q;
	logic [POS_W-1:0]  win_pos_q;
	logic [FILL_W-1:0] win_fill_q;
	logic [10:0]       win_avg_q;
	logic [10:0]       win_mem [AVG_DEPTH];
	logic [10:0]       win_rd_q;

	logic [10:0] load_q;
	logic [31:0] step_q, dist_q;
	logic [15:0] p_q;
	logic        out_valid_q;
	logic [31:0] out_delay_q;
	mode_t       out_mode_q;
	logic [10:0] out_avg_q;

	logic [31:0] div_n_q, div_r_q, div_d_q;
	logic [4:0]  div_cnt_q;
	state_t      div_ret_q;

	// ---------------- combinational helpers ----------------
	logic        accept, out_load;
	logic [10:0] t_sat, l_sat;
	assign accept = sample.valid && sample.ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);
	assign t_sat = (sample.tree_sensor > 16'(SAT_IN)) ? SAT_IN : sample.tree_sensor[10:0];
	assign l_sat = (sample.ingest_sensor > 16'(SAT_IN)) ? SAT_IN : sample.ingest_sensor[10:0];

	logic              win_full;
	logic [SUM_W-1:0]  sum_base, sum_new;
	logic [FILL_W-1:0] fill_new;
	logic [POS_W-1:0]  pos_next;
	assign win_full = win_fill_q >= FILL_W'(AVG_DEPTH);
	assign sum_base = win_full ? ((win_sum_q >= SUM_W'(win_rd_q)) ?
		win_sum_q - SUM_W'(win_rd_q) : '0) : win_sum_q;
	assign sum_new = sum_base + SUM_W'(load_q);
	assign fill_new = win_full ? win_fill_q : win_fill_q + 1'b1;
	assign pos_next = (win_pos_q == POS_W'(AVG_DEPTH - 1)) ? '0 : win_pos_q + 1'b1;

	// divider step
	logic [32:0] div_shift;
	logic [33:0] div_trial;
	logic        div_ge;
	assign div_shift = {div_r_q, div_n_q[31]};
	assign div_trial = {1'b0, div_shift} - {2'b00, div_d_q};
	assign div_ge = !div_trial[33];

	// grow
	logic        g_none, g_top, g_direct, g_need_div;
	logic [31:0] g_den, g_dbl, g_step_direct;
	logic [15:0] g_skip;
	logic [32:0] g_sum;
	logic        g_ok;
	assign g_none = win_avg_q < SCALE;
	assign g_top = win_avg_q >= SAT_IN;
	assign g_dbl = {last_inc_q[30:0], 1'b0};
	assign g_direct = (delay_now_q == 32'd0) || (last_inc_q != 32'd0);
	assign g_step_direct = (delay_now_q == 32'd0) ? 32'(DELAY_MIN) :
		((g_dbl == 32'd0) ? 32'd1 : g_dbl);
	assign g_need_div = !g_none && !(g_top && g_direct);
	always_comb begin
		if (g_top) begin
			g_den = DIV_TOP;
			g_skip = SKIP_TOP;
		end else if (win_avg_q >= G_HI) begin
			g_den = DIV_HI;
			g_skip = SKIP_TOP;
		end else if (win_avg_q > G_MID) begin
			g_den = DIV_MID;
			g_skip = SKIP_MID;
		end else begin
			g_den = DIV_LOW;
			g_skip = SKIP_LOW;
		end
	end
	assign g_sum = {1'b0, delay_now_q} + {1'b0, step_q};
	assign g_ok = (step_q != 32'd0) && !g_sum[32];

	// trial reduction
	logic [15:0] mon_inc;
	logic [31:0] rs_new;
	logic        red_a, red_b, red_go, need_p, c_above_lo;
	logic [9:0]  c_off;
	logic [24:0] p_num;
	logic [47:0] p_prod;
	assign mon_inc = sat_inc(monitor_q);
	assign rs_new = (monitor_q != 16'd0) ? reduce_sum_q + 32'(load_q) : 32'(win_avg_q);
	assign red_a = (div_n_q < C_HI) && (monitor_q >= reduce_ticks_q);
	assign red_b = (div_n_q < C_QTR) && (monitor_q >= {2'b00, reduce_ticks_q[15:2]});
	assign red_go = (red_a || red_b) && (tree_level_q < SCALE);
	assign need_p = (delay_trial_q >= delay_now_q) || (delay_trial_q == 32'd0);
	assign c_above_lo = div_n_q > C_LO;
	assign c_off = div_n_q[9:0] - 10'd100;
	assign p_num = P_SPAN * c_off;
	assign p_prod = p_q * delay_now_q;

	// shrink
	logic               sh_tree_hi, sh_hr_hit, sh_mon_ge, sh_retry, to_idle, clr_win;
	logic signed [32:0] sh_dist, sh_half;
	logic [31:0]        sh_backoff;
	logic [19:0]        inj_dec, inj_new, need_mul;
	logic [20:0]        need;
	logic [15:0]        hr_next;
	logic [2:0]         td_next;
	logic [3:0]         tdp1, tdn_p1;
	assign sh_tree_hi = tree_level_q >= SCALE;
	assign sh_dist = $signed({1'b0, delay_before_q}) - $signed({1'b0, delay_trial_q});
	// signed halving truncates toward zero
	assign sh_half = (sh_dist + $signed({32'd0, sh_dist[32]})) >>> 1;
	assign sh_backoff = delay_before_q - sh_half[31:0];
	assign inj_dec = inject_q - 20'd1;
	assign hr_next = (load_q >= SCALE) ? sat_inc(high_run_q) : 16'd0;
	assign sh_hr_hit = hr_next >= 16'(MAX_HIGH_RUN);
	assign tdp1 = {1'b0, tries_done_q} + 4'd1;
	assign need_mul = inject_ticks_q * tdp1;
	assign need = {1'b0, need_mul} + {5'd0, settle_ticks_q};
	assign sh_mon_ge = {5'd0, mon_inc} >= need;
	assign td_next = tries_done_q + 3'd1;
	assign tdn_p1 = {1'b0, td_next} + 4'd1;
	assign inj_new = inject_ticks_q * tdn_p1;
	assign sh_retry = td_next < tries_allowed_q;

	assign to_idle = (state_q == S_SHRINK) &&
		(sh_tree_hi || sh_hr_hit || (sh_mon_ge && !sh_retry));
	assign clr_win = ((state_q == S_GAPPLY) && g_ok) ||
		((state_q == S_TRYA) && (dist_q != 32'd0));

	// divider launch
	logic        div_go;
	logic [31:0] div_num, div_den;
	state_t      div_ret;
	always_comb begin
		div_go = 1'b0;
		div_num = delay_now_q;
		div_den = g_den;
		div_ret = S_AVG;
		case (state_q)
			S_WIN: begin
				div_go = 1'b1;
				div_num = 32'(sum_new);
				div_den = 32'(fill_new);
				div_ret = S_AVG;
			end
			S_GROW: begin
				div_go = g_need_div;
				div_ret = S_GSTEP;
			end
			S_TRY: begin
				div_go = 1'b1;
				div_num = rs_new;
				div_den = {16'd0, mon_inc};
				div_ret = S_TRY2;
			end
			S_TRY2: begin
				div_go = red_go && need_p && c_above_lo;
				div_num = 32'(p_num);
				div_den = P_DEN;
				div_ret = S_TRYP;
			end
			default: ;
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = (skip_q != 16'd0) ? S_CTRL : S_WIN;
			S_WIN:    state_d = S_DIV;
			S_AVG:    state_d = S_CTRL;
			S_CTRL: begin
				if (disable_q) state_d = S_OUT;
				else if (mode_q == MODE_DEC) state_d = S_SHRINK;
				else if (!win_full) state_d = S_OUT;
				else if (mode_q == MODE_INC || win_avg_q >= SCALE) state_d = S_GROW;
				else state_d = S_TRY;
			end
			S_GROW:   state_d = g_need_div ? S_DIV : S_GAPPLY;
			S_GSTEP:  state_d = S_GAPPLY;
			S_GAPPLY: state_d = S_OUT;
			S_TRY:    state_d = S_DIV;
			S_TRY2: begin
				if (!red_go) state_d = S_OUT;
				else if (!need_p) state_d = S_TRYA;
				else if (c_above_lo) state_d = S_DIV;
				else state_d = S_TRYM;
			end
			S_TRYP:   state_d = S_TRYM;
			S_TRYM:   state_d = S_TRYA;
			S_TRYA:   state_d = (dist_q != 32'd0) ? S_SHRINK : S_OUT;
			S_SHRINK: state_d = S_OUT;
			S_DIV:    if (div_cnt_q == 5'd31) state_d = div_ret_q;
			S_OUT:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// ---------------- outputs ----------------
	always_comb begin
		sample.ready = (state_q == S_IDLE);
		cfg.ready = 1'b1;
		result.valid = out_valid_q;
		result.delay = out_delay_q;
		result.mode = out_mode_q;
		result.average = out_avg_q;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= 32'd0;
			inject_ticks_q <= 16'd10;
			reduce_ticks_q <= 16'd200;
			skip_ticks_q <= 16'd10;
			settle_ticks_q <= 16'd40;
			disable_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_START_DELAY:  start_delay_q <= cfg.data;
				REG_INJECT_TICKS: inject_ticks_q <= cfg.data[15:0];
				REG_REDUCE_TICKS: reduce_ticks_q <= cfg.data[15:0];
				REG_SKIP_TICKS:   skip_ticks_q <= cfg.data[15:0];
				REG_SETTLE_TICKS: settle_ticks_q <= cfg.data[15:0];
				REG_DISABLE:      disable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_now_q <= 32'd0;
			delay_before_q <= 32'd0;
			delay_trial_q <= 32'd0;
			last_inc_q <= 32'd0;
			mode_q <= MODE_NC;
			monitor_q <= 16'd0;
			skip_q <= 16'd0;
			high_run_q <= 16'd0;
			tries_done_q <= 3'd0;
			tries_allowed_q <= 3'd0;
			inject_q <= 20'd0;
			reduce_sum_q <= 32'd0;
			tree_level_q <= 11'd0;
			started_q <= 1'b0;
			win_sum_q <= '0;
			win_pos_q <= '0;
			win_fill_q <= '0;
			win_avg_q <= 11'd0;
			out_valid_q <= 1'b0;
			div_cnt_q <= 5'd0;
			div_ret_q <= S_AVG;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			if (div_go) begin
				div_cnt_q <= 5'd0;
				div_ret_q <= div_ret;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!started_q) begin
							delay_now_q <= start_delay_q;
							started_q <= 1'b1;
						end
						tree_level_q <= t_sat;
						if (skip_q != 16'd0) skip_q <= skip_q - 16'd1;
					end
				end
				S_WIN: begin
					win_sum_q <= sum_new;
					win_fill_q <= fill_new;
					win_pos_q <= pos_next;
				end
				S_AVG: win_avg_q <= div_n_q[10:0];
				S_CTRL: begin
					if (!disable_q && mode_q == MODE_NC && win_full && win_avg_q >= SCALE)
						mode_q <= MODE_INC;
				end
				S_GROW: if (!g_none) skip_q <= g_skip;
				S_GAPPLY: begin
					if (g_ok) begin
						last_inc_q <= step_q;
						delay_now_q <= (g_sum[31:0] > DELAY_MAX) ? DELAY_MAX : g_sum[31:0];
					end else begin
						mode_q <= MODE_NC;
						monitor_q <= 16'd0;
						last_inc_q <= 32'd0;
						delay_trial_q <= 32'd0;
						skip_q <= 16'd0;
					end
				end
				S_TRY: begin
					reduce_sum_q <= rs_new;
					monitor_q <= mon_inc;
				end
				S_TRY2: begin
					if (red_a) tries_allowed_q <= TRIES_FULL;
					else if (red_b) tries_allowed_q <= TRIES_SHORT;
				end
				S_TRYA: begin
					if (dist_q != 32'd0) begin
						delay_before_q <= delay_now_q;
						delay_now_q <= delay_now_q - dist_q;
						delay_trial_q <= delay_now_q - dist_q;
						inject_q <= {4'd0, inject_ticks_q};
						tries_done_q <= 3'd0;
						monitor_q <= 16'd0;
						mode_q <= MODE_DEC;
					end
				end
				S_SHRINK: begin
					if (sh_tree_hi) begin
						delay_now_q <= delay_before_q;
					end else begin
						if (inject_q != 20'd0) begin
							inject_q <= inj_dec;
							if (inj_dec == 20'd0) delay_now_q <= delay_before_q;
						end
						high_run_q <= hr_next;
						if (sh_hr_hit) begin
							delay_now_q <= delay_before_q;
							delay_trial_q <= sh_backoff;
						end else if (sh_mon_ge) begin
							high_run_q <= 16'd0;
							monitor_q <= 16'd0;
							tries_done_q <= td_next;
							delay_now_q <= delay_trial_q;
							if (sh_retry) inject_q <= inj_new;
						end else begin
							monitor_q <= mon_inc;
						end
					end
				end
				default: ;
			endcase

			if (to_idle) begin
				mode_q <= MODE_NC;
				high_run_q <= 16'd0;
				monitor_q <= 16'd0;
				tries_done_q <= 3'd0;
				skip_q <= skip_ticks_q;
			end
			if (to_idle || clr_win) begin
				win_avg_q <= 11'd0;
				win_pos_q <= '0;
				win_sum_q <= '0;
				win_fill_q <= '0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) load_q <= l_sat;
		if (div_go) begin
			div_n_q <= div_num;
			div_r_q <= 32'd0;
			div_d_q <= div_den;
		end else if (state_q == S_DIV) begin
			div_n_q <= {div_n_q[30:0], div_ge};
			div_r_q <= div_ge ? div_trial[31:0] : div_shift[31:0];
		end
		case (state_q)
			S_GROW:  step_q <= g_none ? 32'd0 : g_step_direct;
			S_GSTEP: step_q <= (div_n_q == 32'd0) ? 32'd1 : div_n_q;
			S_TRY2: begin
				p_q <= P_MAX;
				dist_q <= delay_now_q - delay_trial_q;
			end
			S_TRYP:  p_q <= P_MAX - div_n_q[15:0];
			S_TRYM:  dist_q <= p_prod[47:16];
			default: ;
		endcase
		if (out_load) begin
			out_delay_q <= disable_q ? 32'd0 : delay_now_q;
			out_mode_q <= mode_q;
			out_avg_q <= win_avg_q;
		end
	end

	// window store
	always_ff @(posedge clk) begin
		if (state_q == S_WIN) win_mem[win_pos_q] <= load_q;
		win_rd_q <= win_mem[win_pos_q];
	end

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_fill_q <= FILL_W'(AVG_DEPTH))
		else $error("window fill beyond depth");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_NC) || (mode_q == MODE_INC) || (mode_q == MODE_DEC))
		else $error("illegal control mode");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_d_q != 32'd0))
		else $error("divide by zero");

endmodule

FILE: verif/tb_adaptive_delay_throttle.sv
`timescale 1ns / 100ps

module tb_adaptive_delay_throttle;
	import adt_pkg::*;

	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned HIGH_RUN_LIMIT = 8;
	localparam logic [31:0] CEIL_DELAY = 32'd1000000;
	localparam int unsigned STALL_LIMIT = 6000;

	typedef struct packed {
		logic [31:0] delay;
		mode_t       mode;
		logic [10:0] average;
	} tick_result_t;

	class throttle_scoreboard;
		// register copies
		bit [31:0] start_delay;
		bit [15:0] inject_ticks, reduce_ticks, skip_ticks, settle_ticks;
		bit        disabled;
		// controller state
		bit [31:0] delay_now, delay_before, delay_trial, last_step, reduce_sum;
		mode_t     ctl_mode;
		bit [15:0] monitor_cnt, skip_cnt, high_run;
		bit [2:0]  tries_done, tries_allowed;
		bit [19:0] inj_left;
		bit [10:0] tree_level, win_avg;
		bit [10:0] win_samples [WIN_DEPTH];
		bit [15:0] win_sum;
		bit [3:0]  win_pos;
		bit [4:0]  win_fill;
		bit        started;
		tick_result_t pending_q[$];
		int errors, checked, ticks, inc_ticks, dec_ticks;

		function new();
			inject_ticks = 16'd10;
			reduce_ticks = 16'd200;
			skip_ticks = 16'd10;
			settle_ticks = 16'd40;
			ctl_mode = MODE_NC;
			foreach (win_samples[i]) win_samples[i] = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, bit [31:0] d);
			case (idx)
				REG_START_DELAY:  start_delay = d;
				REG_INJECT_TICKS: inject_ticks = d[15:0];
				REG_REDUCE_TICKS: reduce_ticks = d[15:0];
				REG_SKIP_TICKS:   skip_ticks = d[15:0];
				REG_SETTLE_TICKS: settle_ticks = d[15:0];
				REG_DISABLE:      disabled = d[0];
				default: ;
			endcase
		endfunction

		function bit [15:0] bump(bit [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function void clear_window();
			win_avg = '0;
			win_pos = '0;
			win_sum = '0;
			win_fill = '0;
		endfunction

		function void go_idle();
			ctl_mode = MODE_NC;
			high_run = '0;
			monitor_cnt = '0;
			tries_done = '0;
			skip_cnt = skip_ticks;
			clear_window();
		endfunction

		function void grow(bit [10:0] value);
			bit [31:0] step;
			longint unsigned sum;
			step = '0;
			if (value >= SAT_IN) begin
				step = (last_step != 0) ? (last_step << 1) : delay_now / DIV_TOP;
				if (step < 1) step = 1;
				if (delay_now == 0) step = 32'd1;
				skip_cnt = SKIP_TOP;
			end else if (value >= G_HI) begin
				step = delay_now / DIV_HI;
				if (step < 1) step = 1;
				skip_cnt = SKIP_TOP;
			end else if (value > G_MID) begin
				step = delay_now / DIV_MID;
				if (step < 1) step = 1;
				skip_cnt = SKIP_MID;
			end else if (value >= SCALE) begin
				step = delay_now / DIV_LOW;
				if (step < 1) step = 1;
				skip_cnt = SKIP_LOW;
			end
			sum = longint'({32'd0, delay_now}) + longint'({32'd0, step});
			if (step != 0 && sum <= 64'hFFFF_FFFF) begin
				last_step = step;
				delay_now = (sum > CEIL_DELAY) ? CEIL_DELAY : sum[31:0];
				clear_window();
			end else begin
				ctl_mode = MODE_NC;
				monitor_cnt = '0;
				last_step = '0;
				delay_trial = '0;
				skip_cnt = '0;
			end
		endfunction

		function void shrink(bit [10:0] load);
			longint gap, need;
			int unsigned k;
			gap = $signed({32'd0, delay_before}) - $signed({32'd0, delay_trial});
			if (tree_level >= SCALE) begin
				delay_now = delay_before;
				go_idle();
				return;
			end
			if (inj_left > 0) begin
				inj_left--;
				if (inj_left == 0) delay_now = delay_before;
			end
			high_run = (load >= SCALE) ? bump(high_run) : 16'd0;
			if (high_run >= HIGH_RUN_LIMIT) begin
				longint backed;
				backed = $signed({32'd0, delay_before}) - gap / 2;
				delay_now = delay_before;
				delay_trial = backed[31:0];
				go_idle();
				return;
			end
			monitor_cnt = bump(monitor_cnt);
			k = tries_done;
			need = longint'(inject_ticks) * longint'(k + 1) + longint'(settle_ticks);
			if (longint'(monitor_cnt) >= need) begin
				high_run = '0;
				monitor_cnt = '0;
				tries_done = tries_done + 3'd1;
				delay_now = delay_trial;
				if (tries_done < tries_allowed) begin
					k = tries_done;
					k = inject_ticks * (k + 1);
					inj_left = k[19:0];
				end else begin
					go_idle();
				end
			end
		endfunction

		function void try_reduce(bit [10:0] load);
			bit do_cut;
			bit [31:0] c, p;
			longint gap;
			longint unsigned prod;
			do_cut = 0;
			if (monitor_cnt != 0) reduce_sum = reduce_sum + load;
			else reduce_sum = win_avg;
			monitor_cnt = bump(monitor_cnt);
			c = reduce_sum / monitor_cnt;
			if (c < C_HI && monitor_cnt >= reduce_ticks) begin
				do_cut = 1;
				tries_allowed = TRIES_FULL;
			end else if (c < C_QTR && monitor_cnt >= reduce_ticks / 4) begin
				do_cut = 1;
				tries_allowed = TRIES_SHORT;
			end
			if (!do_cut || tree_level >= SCALE) return;
			gap = $signed({32'd0, delay_now}) - $signed({32'd0, delay_trial});
			if (gap <= 0 || gap >= $signed({32'd0, delay_now})) begin
				p = P_MAX;
				if (c > C_LO) p = P_MAX - (P_SPAN * (c - C_LO)) / P_DEN;
				prod = (longint'(p) * longint'({32'd0, delay_now})) >> 16;
				gap = prod;
			end
			if (gap > 0) begin
				delay_before = delay_now;
				delay_now = delay_now - gap[31:0];
				delay_trial = delay_now;
				inj_left = {4'd0, inject_ticks};
				tries_done = '0;
				monitor_cnt = '0;
				ctl_mode = MODE_DEC;
				shrink(load);
				clear_window();
			end
		endfunction

		// accepted sample transaction: advance the model and queue the tick result
		function void note_sample(bit [15:0] tree, bit [15:0] ingest);
			bit [10:0] load, old;
			tick_result_t r;
			ticks++;
			if (!started) begin
				delay_now = start_delay;
				started = 1;
			end
			tree_level = (tree > SAT_IN) ? SAT_IN : tree[10:0];
			load = (ingest > SAT_IN) ? SAT_IN : ingest[10:0];
			if (skip_cnt > 0) begin
				skip_cnt--;
			end else begin
				if (win_fill >= WIN_DEPTH) begin
					old = win_samples[win_pos];
					win_sum = (win_sum >= old) ? win_sum - old : 16'd0;
				end else begin
					win_fill++;
				end
				win_samples[win_pos] = load;
				win_sum = win_sum + load;
				win_pos++;
				win_avg = win_sum / win_fill;
			end
			if (!disabled) begin
				if (ctl_mode == MODE_DEC) begin
					shrink(load);
				end else if (ctl_mode == MODE_INC) begin
					if (win_fill >= WIN_DEPTH) grow(win_avg);
				end else if (win_fill >= WIN_DEPTH) begin
					if (win_avg >= SCALE) begin
						ctl_mode = MODE_INC;
						grow(win_avg);
					end else begin
						try_reduce(load);
					end
				end
			end
			if (ctl_mode == MODE_INC) inc_ticks++;
			if (ctl_mode == MODE_DEC) dec_ticks++;
			r.delay = disabled ? 32'd0 : delay_now;
			r.mode = ctl_mode;
			r.average = win_avg;
			pending_q.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_result(tick_result_t got);
			tick_result_t want;
			if (pending_q.size() == 0) begin
				report("result with no tick pending");
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (got.delay !== want.delay)
				report($sformatf("delay got %0d want %0d", got.delay, want.delay));
			if (got.mode !== want.mode)
				report($sformatf("mode got %0d want %0d", got.mode, want.mode));
			if (got.average !== want.average)
				report($sformatf("average got %0d want %0d", got.average, want.average));
		endtask
	endclass

	logic clk;
	logic arst_n;
	adt_in_if  sample();
	adt_out_if result();
	adt_cfg_if cfg();

	adaptive_delay_throttle u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	throttle_scoreboard sb = new();
	bit no_idle;
	bit hold_req;
	int hold_len;
	int stall_cycles;
	bit high_regime;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		sample.valid = 1'b0;
		sample.tree_sensor = '0;
		sample.ingest_sensor = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_START_DELAY;
		cfg.data = '0;
	end

	always @(posedge clk) begin
		if (arst_n && sample.valid && sample.ready)
			sb.note_sample(sample.tree_sensor, sample.ingest_sensor);
		if (arst_n && result.valid && result.ready)
			sb.check_result({result.delay, result.mode, result.average});
	end

	// result sink with random stalls and one requested long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_req = 0;
				result.ready <= 1'b1;
			end else begin
				result.ready <= (!no_idle && $urandom_range(99) < 18) ? 1'b0 : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready) || !arst_n || hold_req)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task write_reg(cfg_idx_t idx, logic [31:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, d);
	endtask

	task write_all(logic [31:0] sd, logic [15:0] inj, logic [15:0] red, logic [15:0] skp,
			logic [15:0] stl, logic dis);
		write_reg(REG_START_DELAY, sd);
		write_reg(REG_INJECT_TICKS, {16'd0, inj});
		write_reg(REG_REDUCE_TICKS, {16'd0, red});
		write_reg(REG_SKIP_TICKS, {16'd0, skp});
		write_reg(REG_SETTLE_TICKS, {16'd0, stl});
		write_reg(REG_DISABLE, {31'd0, dis});
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task send_tick(logic [15:0] tree, logic [15:0] ingest);
		if (!no_idle && $urandom_range(99) < 18) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.tree_sensor <= tree;
		sample.ingest_sensor <= ingest;
		do @(posedge clk); while (!sample.ready);
	endtask

	task send_random(int n);
		logic [15:0] tree, ingest;
		int run;
		run = 0;
		repeat (n) begin
			if (run == 0) begin
				high_regime = $urandom_range(1);
				run = $urandom_range(20, 80);
			end
			run--;
			if ($urandom_range(99) < 8) begin
				tree = $urandom;
				ingest = $urandom;
			end else begin
				case ($urandom_range(19))
					0, 1:    tree = $urandom_range(1000, 2000);
					2:       tree = $urandom;
					default: tree = $urandom_range(0, 999);
				endcase
				if (high_regime)
					ingest = ($urandom_range(3) == 0) ? 16'd2000 : $urandom_range(1000, 2000);
				else if ($urandom_range(1))
					ingest = $urandom_range(0, 249);
				else
					ingest = $urandom_range(250, 899);
			end
			send_tick(tree, ingest);
		end
		sample.valid <= 1'b0;
	endtask

	// all results in before touching registers
	task drain();
		int waited;
		waited = 0;
		while (sb.pending_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_all(32'd20000, 16'd3, 16'd6, 16'd0, 16'd2, 1'b0);

		// field extremes, then a full window of saturated load
		send_tick(16'd0, 16'd0);
		send_tick(16'hFFFF, 16'hFFFF);
		send_tick(16'd2000, 16'd2000);
		send_tick(16'd2001, 16'd1999);
		send_tick(16'd1999, 16'd2001);
		send_tick(16'd999, 16'd1000);
		send_tick(16'd1000, 16'd999);
		send_tick(16'h5555, 16'hAAAA);
		send_tick(16'hAAAA, 16'h5555);
		repeat (15) send_tick(16'd0, 16'hFFFF);
		send_random(230);
		drain();

		// disabled: late start_delay write must stay without effect
		write_all(32'hFFFF_FFFF, 16'd10, 16'd200, 16'd10, 16'd40, 1'b1);
		send_random(60);
		drain();

		// tightest timing, no idling, long sink hold-off to back up the input
		write_all(32'd0, 16'd1, 16'd1, 16'd0, 16'd0, 1'b0);
		no_idle = 1;
		hold_len = 400;
		hold_req = 1;
		send_random(250);
		drain();
		no_idle = 0;

		write_all(32'd777, 16'd2, 16'd12, 16'd5, 16'd3, 1'b0);
		send_random(250);
		drain();

		write_all(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_random(90);
		drain();
		repeat (200) @(posedge clk);

		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d tick results never arrived", sb.pending_q.size()));
		$display("ran %0d ticks, checked %0d results over 5 register settings",
			sb.ticks, sb.checked);
		$display("ticks in increase mode %0d, in decrease trial %0d, mismatches %0d",
			sb.inc_ticks, sb.dec_ticks, sb.errors);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
